// ===== sv/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpa_pkg
// shared widths, request and status codes and defaults of the block pool
// allocator
// ----------------------------------------------------------------------------
package fbpa_pkg;

   localparam int ADDR_W   = 32;
   localparam int BYTES_W  = 16;
   localparam int TOTAL_W  = 9;
   localparam int COUNT_W  = 9;
   localparam int REQ_W    = 2;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam int DEF_MAX_BLOCKS      = 256;
   localparam int DEF_MIN_BLOCK_BYTES = 4;

   localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
   localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_INIT  = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BAD_INIT = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BYTES  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_TOTAL  = 2'd2;

   localparam logic [ADDR_W-1:0]  RST_BASE_ADDRESS = 32'd0;
   localparam logic [BYTES_W-1:0] RST_BLOCK_BYTES  = 16'd32;
   localparam logic [TOTAL_W-1:0] RST_BLOCK_TOTAL  = 9'd16;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   block_addr;
      logic                addr_in_pool;
      logic [COUNT_W-1:0]  free_count;
   } rsp_word_type;

endpackage

// ===== sv/fbpa_req_if.sv =====
// ----------------------------------------------------------------------------
// fbpa_req_if
// request channel: request type and address word with valid/ready
// ----------------------------------------------------------------------------
interface fbpa_req_if
   import fbpa_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [REQ_W-1:0]  req_type;
   logic [ADDR_W-1:0] addr;

   modport source (output valid, output req_type, output addr, input ready);
   modport sink   (input valid, input req_type, input addr, output ready);
endinterface

// ===== sv/fbpa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fbpa_rsp_if
// result channel: status, given block, pool membership and free count word
// ----------------------------------------------------------------------------
interface fbpa_rsp_if
   import fbpa_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   block_addr;
   logic                addr_in_pool;
   logic [COUNT_W-1:0]  free_count;

   modport source (output valid, output status, output block_addr,
                   output addr_in_pool, output free_count, input ready);
   modport sink   (input valid, input status, input block_addr,
                   input addr_in_pool, input free_count, output ready);
endinterface

// ===== sv/fbpa_ram.sv =====
// ----------------------------------------------------------------------------
// fbpa_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module fbpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/fixed_block_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// pool of equal-sized blocks handed out and taken back through a fifo free
// list held in a ram
// ----------------------------------------------------------------------------
// usage:
//   csr port sets base address, block size and block count; write it only
//   while no request is outstanding.
//   req_ch takes one word: allocate, free or init, plus an address that is
//   freed and always checked against the pool range.
//   rsp_ch returns one word per request: status, given block, membership
//   flag and free count after the request.
// timing (accept edge to result valid):
//   free, rejected or unknown requests: the result word is registered on accept,
//   one per cycle when the receiver keeps up
//   allocate with a free block: the free-list ram read is registered, then the result word
//   init: one free-list entry written per cycle, then the result word
// reset clears pointers, free count and pool range; the free-list ram is
// not cleared and needs an init or frees before an allocate can succeed.
// a stalled receiver holds the result in the output register; a new
// request is taken only when that register is empty or being emptied.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator
   import fbpa_pkg::*;
#(
   parameter int MAX_BLOCKS      = DEF_MAX_BLOCKS,
   parameter int MIN_BLOCK_BYTES = DEF_MIN_BLOCK_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   fbpa_req_if.sink              req_ch,
   fbpa_rsp_if.source            rsp_ch
);

   localparam int PTR_W  = $clog2(MAX_BLOCKS);
   localparam int FREE_W = $clog2(MAX_BLOCKS + 1);
   localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(MAX_BLOCKS - 1);
   localparam logic [FREE_W-1:0] FREE_MAX = FREE_W'(MAX_BLOCKS);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ALLOC = 2'd1;
   localparam logic [1:0] ST_INIT  = 2'd2;

   logic [ADDR_W-1:0]  base_address_ff;
   logic [BYTES_W-1:0] block_bytes_ff;
   logic [TOTAL_W-1:0] block_total_ff;

   logic [1:0]         state_ff, state_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [FREE_W-1:0]  free_ff, free_in;
   logic [ADDR_W-1:0]  pool_first_ff, pool_first_in;
   logic [ADDR_W-1:0]  pool_last_ff, pool_last_in;
   logic [PTR_W-1:0]   idx_ff, idx_in;
   logic [ADDR_W-1:0]  acc_ff, acc_in;
   logic [ADDR_W-1:0]  req_addr_ff, req_addr_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_ff, rsp_in;

   logic               req_ready;
   logic               req_fire;
   logic               load_rsp;
   logic [STATUS_W-1:0] load_status;
   logic [ADDR_W-1:0]  load_given;
   logic [ADDR_W-1:0]  chk_addr;
   logic [31:0]        total32;
   logic [31:0]        total_m1;
   logic               init_bad;
   logic [31:0]        free32;

   logic               ram_we;
   logic [PTR_W-1:0]   ram_wa;
   logic [ADDR_W-1:0]  ram_wd;
   logic               ram_re;
   logic [ADDR_W-1:0]  ram_rd;

   fbpa_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (MAX_BLOCKS)
   ) u_free_list (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (head_ff),
      .rd_data (ram_rd)
   );

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff <= RST_BASE_ADDRESS;
         block_bytes_ff  <= RST_BLOCK_BYTES;
         block_total_ff  <= RST_BLOCK_TOTAL;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BASE_ADDRESS: base_address_ff <= csr_wr_data[ADDR_W-1:0];
            CSR_BLOCK_BYTES:  block_bytes_ff  <= csr_wr_data[BYTES_W-1:0];
            CSR_BLOCK_TOTAL:  block_total_ff  <= csr_wr_data[TOTAL_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_fire  = req_ch.valid && req_ready;
   assign total32   = 32'(block_total_ff);
   assign total_m1  = total32 - 32'd1;
   assign init_bad  = (total32 == 32'd0) || (total32 > 32'(MAX_BLOCKS)) ||
                      (32'(block_bytes_ff) < 32'(MIN_BLOCK_BYTES));

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_in       = free_ff;
      pool_first_in = pool_first_ff;
      pool_last_in  = pool_last_ff;
      idx_in        = idx_ff;
      acc_in        = acc_ff;
      req_addr_in   = req_addr_ff;
      ram_we        = 1'b0;
      ram_wa        = tail_ff;
      ram_wd        = req_ch.addr;
      ram_re        = 1'b0;
      load_rsp      = 1'b0;
      load_status   = STAT_OK;
      load_given    = '0;
      chk_addr      = req_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_in        = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            chk_addr = req_ch.addr;
            if (req_fire) begin
               req_addr_in = req_ch.addr;
               case (req_ch.req_type)
                  REQ_ALLOC: begin
                     if (free_ff == '0) begin
                        load_rsp    = 1'b1;
                        load_status = STAT_EMPTY;
                     end else begin
                        ram_re   = 1'b1;
                        head_in  = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_W'(1);
                        free_in  = free_ff - FREE_W'(1);
                        state_in = ST_ALLOC;
                     end
                  end
                  REQ_FREE: begin
                     load_rsp = 1'b1;
                     if (free_ff == FREE_MAX) begin
                        load_status = STAT_OVERFLOW;
                     end else begin
                        ram_we  = 1'b1;
                        tail_in = (tail_ff == PTR_LAST) ? '0 : tail_ff + PTR_W'(1);
                        free_in = free_ff + FREE_W'(1);
                     end
                  end
                  REQ_INIT: begin
                     if (init_bad) begin
                        load_rsp    = 1'b1;
                        load_status = STAT_BAD_INIT;
                     end else begin
                        idx_in   = '0;
                        acc_in   = base_address_ff;
                        state_in = ST_INIT;
                     end
                  end
                  default: begin
                     load_rsp = 1'b1;
                  end
               endcase
            end
         end
         ST_ALLOC: begin
            load_rsp   = 1'b1;
            load_given = ram_rd;
            state_in   = ST_IDLE;
         end
         ST_INIT: begin
            ram_we = 1'b1;
            ram_wa = idx_ff;
            ram_wd = acc_ff;
            acc_in = acc_ff + ADDR_W'(block_bytes_ff);
            idx_in = idx_ff + PTR_W'(1);
            if (idx_ff == total_m1[PTR_W-1:0]) begin
               pool_first_in = base_address_ff;
               pool_last_in  = acc_ff;
               head_in       = '0;
               tail_in       = (total32 >= 32'(MAX_BLOCKS)) ? '0 : total32[PTR_W-1:0];
               free_in       = total32[FREE_W-1:0];
               load_rsp      = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      free32 = 32'(free_in);
      if (load_rsp) begin
         rsp_valid_in        = 1'b1;
         rsp_in.status       = load_status;
         rsp_in.block_addr   = load_given;
         rsp_in.addr_in_pool = (chk_addr >= pool_first_in) && (chk_addr <= pool_last_in);
         rsp_in.free_count   = free32[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         free_ff       <= '0;
         pool_first_ff <= '0;
         pool_last_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         free_ff       <= free_in;
         pool_first_ff <= pool_first_in;
         pool_last_ff  <= pool_last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      acc_ff      <= acc_in;
      req_addr_ff <= req_addr_in;
      rsp_ff      <= rsp_in;
   end

   assign req_ch.ready        = req_ready;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_ff.status;
   assign rsp_ch.block_addr   = rsp_ff.block_addr;
   assign rsp_ch.addr_in_pool = rsp_ff.addr_in_pool;
   assign rsp_ch.free_count   = rsp_ff.free_count;

`ifndef SYNTHESIS
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= FREE_MAX)
      else $error("free count above pool depth");

   a_ptr_consistent: assert property (@(posedge clock) disable iff (reset)
      (32'(head_ff) + 32'(free_ff) == 32'(tail_ff)) ||
      (32'(head_ff) + 32'(free_ff) == 32'(tail_ff) + 32'(MAX_BLOCKS)))
      else $error("head, tail and free count disagree");

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ALLOC || state_ff == ST_INIT) |-> !rsp_valid_ff)
      else $error("result word pending while a request is in progress");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STAT_EMPTY) |->
      (rsp_ff.free_count == '0 && rsp_ff.block_addr == '0))
      else $error("empty status with blocks reported free");
`endif

endmodule

// ===== verif/tb_fixed_block_pool_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fixed_block_pool_allocator
// self-checking bench for the block pool allocator: a scoreboard keeps its own
// copy of the free list, pool range and registers, predicts one result word
// per accepted request and checks every returned word field by field.
// directed requests cover the empty, overflow, bad-init, wrapped-range and
// unknown-request cases; random sessions follow, each one reprogramming the
// pool and mixing allocates, frees of lent blocks, stray frees and re-inits
// under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_fixed_block_pool_allocator;
   import fbpa_pkg::*;

   localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
   localparam int ITEMS       = 1200;
   localparam int CALM_ITEMS  = 150;
   localparam int CYCLE_LIMIT = 500000;

   class pool_scoreboard;
      logic [ADDR_W-1:0]  base_address;
      logic [BYTES_W-1:0] block_bytes;
      logic [TOTAL_W-1:0] block_total;
      logic [ADDR_W-1:0]  slot_addr [DEF_MAX_BLOCKS];
      int                 pop_idx;
      int                 push_idx;
      int                 free_now;
      logic [ADDR_W-1:0]  range_lo;
      logic [ADDR_W-1:0]  range_hi;
      rsp_word_type       pending_rsp [$];
      int                 errors;

      function new();
         base_address = RST_BASE_ADDRESS;
         block_bytes  = RST_BLOCK_BYTES;
         block_total  = RST_BLOCK_TOTAL;
         foreach (slot_addr[i]) slot_addr[i] = '0;
         pop_idx  = 0;
         push_idx = 0;
         free_now = 0;
         range_lo = '0;
         range_hi = '0;
         errors   = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_BASE_ADDRESS: base_address = data[ADDR_W-1:0];
            CSR_BLOCK_BYTES:  block_bytes  = data[BYTES_W-1:0];
            CSR_BLOCK_TOTAL:  block_total  = data[TOTAL_W-1:0];
            default: ;
         endcase
      endfunction

      function rsp_word_type note_request(logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] addr);
         rsp_word_type      w;
         logic [ADDR_W-1:0] a;
         int                i;
         w.status     = STAT_OK;
         w.block_addr = '0;
         case (kind)
            REQ_ALLOC: begin
               if (free_now == 0) begin
                  w.status = STAT_EMPTY;
               end else begin
                  w.block_addr = slot_addr[pop_idx];
                  pop_idx  = (pop_idx + 1) % DEF_MAX_BLOCKS;
                  free_now = free_now - 1;
               end
            end
            REQ_FREE: begin
               if (free_now >= DEF_MAX_BLOCKS) begin
                  w.status = STAT_OVERFLOW;
               end else begin
                  slot_addr[push_idx] = addr;
                  push_idx = (push_idx + 1) % DEF_MAX_BLOCKS;
                  free_now = free_now + 1;
               end
            end
            REQ_INIT: begin
               if (block_total == 0 || block_total > DEF_MAX_BLOCKS ||
                   block_bytes < DEF_MIN_BLOCK_BYTES) begin
                  w.status = STAT_BAD_INIT;
               end else begin
                  a = base_address;
                  for (i = 0; i < block_total; i++) begin
                     slot_addr[i] = a;
                     range_hi = a;
                     a = a + block_bytes;
                  end
                  range_lo = base_address;
                  pop_idx  = 0;
                  push_idx = block_total % DEF_MAX_BLOCKS;
                  free_now = block_total;
               end
            end
            default: ;
         endcase
         w.addr_in_pool = (addr >= range_lo) && (addr <= range_hi);
         w.free_count   = COUNT_W'(free_now);
         pending_rsp.push_back(w);
         return w;
      endfunction

      function void check_result(rsp_word_type got);
         rsp_word_type exp;
         if (pending_rsp.size() == 0) begin
            $error("unexpected result word: status %0d block_addr %h",
                   got.status, got.block_addr);
            errors++;
            return;
         end
         exp = pending_rsp.pop_front();
         if (got.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got.status);
            errors++;
         end
         if (got.block_addr !== exp.block_addr) begin
            $error("block_addr: expected %h, got %h", exp.block_addr, got.block_addr);
            errors++;
         end
         if (got.addr_in_pool !== exp.addr_in_pool) begin
            $error("addr_in_pool: expected %0d, got %0d", exp.addr_in_pool, got.addr_in_pool);
            errors++;
         end
         if (got.free_count !== exp.free_count) begin
            $error("free_count: expected %0d, got %0d", exp.free_count, got.free_count);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   fbpa_req_if req_ch ();
   fbpa_rsp_if rsp_ch ();

   fixed_block_pool_allocator u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   pool_scoreboard    sb;
   logic [ADDR_W-1:0] lent [$];
   int                sent;
   int                cycles;
   int                send_odds;
   int                stall_odds;
   int                stall_left;
   bit                calm;
   bit                req_up;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
         stall_left = $urandom_range(0, 12);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result({rsp_ch.status, rsp_ch.block_addr, rsp_ch.addr_in_pool,
                          rsp_ch.free_count});
   end

   function automatic logic [ADDR_W-1:0] probe_addr();
      case ($urandom_range(0, 6))
         0: return sb.range_lo;
         1: return sb.range_hi;
         2: return sb.range_lo - 1;
         3: return sb.range_hi + 1;
         4: return sb.range_lo + $urandom_range(0, sb.range_hi - sb.range_lo);
         default: return $urandom();
      endcase
   endfunction

   task automatic send_request(input logic [REQ_W-1:0] kind, input logic [ADDR_W-1:0] addr);
      rsp_word_type w;
      int           gap;
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= kind;
      req_ch.addr     <= addr;
      req_up = 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      w = sb.note_request(kind, addr);
      sent++;
      if (kind == REQ_ALLOC && w.status == STAT_OK) lent.push_back(w.block_addr);
      if (kind == REQ_INIT && w.status == STAT_OK) lent.delete();
      if (!calm && send_odds != 0 && $urandom_range(1, send_odds) == 1) begin
         gap = $urandom_range(1, 13);
         req_ch.valid <= 1'b0;
         req_up = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle();
      if (req_up) begin
         req_ch.valid <= 1'b0;
         req_up = 1'b0;
      end
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      sb.set_register(idx, data);
   endtask

   // pick bits: base address, block size, block count
   task automatic program_pool(input bit [2:0] pick, input logic [ADDR_W-1:0] base,
                               input logic [BYTES_W-1:0] bytes,
                               input logic [TOTAL_W-1:0] total);
      settle();
      if (pick[0]) write_reg(CSR_BASE_ADDRESS, base);
      if (pick[1]) write_reg(CSR_BLOCK_BYTES, CSR_DATA_W'(bytes));
      if (pick[2]) write_reg(CSR_BLOCK_TOTAL, CSR_DATA_W'(total));
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_session(input int n, input int alloc_pct);
      int                r;
      int                k;
      logic [ADDR_W-1:0] a;
      send_request(REQ_INIT, probe_addr());
      for (int i = 1; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < alloc_pct) begin
            send_request(REQ_ALLOC, probe_addr());
         end else if (r < 90) begin
            if (lent.size() != 0 && $urandom_range(0, 3) != 0) begin
               k = $urandom_range(0, lent.size() - 1);
               a = lent[k];
               lent.delete(k);
            end else begin
               a = probe_addr();
            end
            send_request(REQ_FREE, a);
         end else if (r < 95) begin
            send_request(REQ_INIT, probe_addr());
         end else if (r < 98) begin
            send_request(REQ_FREE, $urandom());
         end else begin
            send_request(REQ_UNKNOWN, probe_addr());
         end
      end
   endtask

   initial begin
      bit [2:0]           pick;
      logic [ADDR_W-1:0]  base;
      logic [BYTES_W-1:0] bytes;
      logic [TOTAL_W-1:0] total;
      int                 alloc_pct;

      sb         = new();
      sent       = 0;
      cycles     = 0;
      calm       = 1'b0;
      req_up     = 1'b0;
      stall_left = 0;
      send_odds  = 4;
      stall_odds = 4;
      reset           <= 1'b1;
      csr_wr_en       <= 1'b0;
      csr_index       <= CSR_BASE_ADDRESS;
      csr_wr_data     <= '0;
      req_ch.valid    <= 1'b0;
      req_ch.req_type <= REQ_ALLOC;
      req_ch.addr     <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // before any init only address zero is in the pool
      send_request(REQ_ALLOC, 32'h0000_0000);
      send_request(REQ_UNKNOWN, 32'h0000_0001);
      send_request(REQ_FREE, 32'hFFFF_FFFF);
      send_request(REQ_ALLOC, 32'h0000_0000);
      send_request(REQ_INIT, 32'h0000_01E0);
      send_request(REQ_ALLOC, 32'h0000_01E1);
      send_request(REQ_FREE, 32'h0000_0000);

      // full pool wrapping past the top of the address space
      program_pool(3'b111, 32'hFFFF_FFF0, 16'hFFFF, 9'd256);
      send_request(REQ_INIT, 32'hFFFF_FFF0);
      send_request(REQ_FREE, 32'h1234_5678);
      send_request(REQ_ALLOC, 32'hFFFF_FFFF);
      send_request(REQ_FREE, 32'h0000_0000);
      send_request(REQ_FREE, 32'h8000_0000);
      send_request(REQ_UNKNOWN, 32'hFFFF_FFF0);

      // rejected inits leave the pool as it was
      program_pool(3'b010, '0, 16'd3, '0);
      send_request(REQ_INIT, 32'h0000_0000);
      program_pool(3'b010, '0, 16'd0, '0);
      send_request(REQ_INIT, 32'h7FFF_FFFF);
      program_pool(3'b110, '0, 16'd4, 9'd0);
      send_request(REQ_INIT, 32'hFFFF_FFF0);

      program_pool(3'b101, 32'h0000_0000, '0, 9'd1);
      send_request(REQ_INIT, 32'h0000_0000);
      send_request(REQ_ALLOC, 32'h0000_0000);
      send_request(REQ_ALLOC, 32'h0000_0003);

      while (sent < ITEMS) begin
         pick = 3'($urandom_range(1, 7));
         case ($urandom_range(0, 4))
            0: base = '0;
            1: base = 32'hFFFF_FFFF - $urandom_range(0, 4096);
            2: base = '1;
            default: base = $urandom();
         endcase
         case ($urandom_range(0, 9))
            0: bytes = 16'($urandom_range(0, 3));
            1: bytes = 16'hFFFF;
            2: bytes = 16'($urandom_range(0, 65535));
            default: bytes = 16'($urandom_range(4, 64));
         endcase
         case ($urandom_range(0, 11))
            0: total = '0;
            1: total = 9'd256;
            2: total = 9'($urandom_range(0, 256));
            default: total = 9'($urandom_range(1, 24));
         endcase
         case ($urandom_range(0, 2))
            0: alloc_pct = 15;
            1: alloc_pct = 45;
            default: alloc_pct = 60;
         endcase
         if (sent >= ITEMS - CALM_ITEMS) begin
            calm       = 1'b1;
            send_odds  = 0;
            stall_odds = 0;
         end else begin
            case ($urandom_range(0, 2))
               0: send_odds = 0;
               1: send_odds = 12;
               default: send_odds = 3;
            endcase
            case ($urandom_range(0, 2))
               0: stall_odds = 0;
               1: stall_odds = 12;
               default: stall_odds = 3;
            endcase
         end
         program_pool(pick, base, bytes, total);
         run_session($urandom_range(20, 60), alloc_pct);
      end

      settle();
      repeat (20) @(posedge clock);
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
